[hdl/aisp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_pkg
// Shared constants, codes and result types of the archive index stream parser.
// ----------------------------------------------------------------------------
package aisp_pkg;

   localparam int HEADER_BYTES = 24;
   localparam int REC_BYTES    = 36;
   localparam int REC_LAST     = REC_BYTES - 1;
   localparam int REC_FIELD_LO = 16;
   localparam int REC_FIELD_HI = 32;
   localparam int VER_MIN      = 1;
   localparam int VER_MAX      = 8;

   // "BTDX" and "GNRL"
   localparam logic [31:0] MAGIC_TAG = 32'h5844_5442;
   localparam logic [31:0] TYPE_TAG  = 32'h4C52_4E47;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
   localparam logic [2:0] ST_BAD_VERSION = 3'd3;
   localparam logic [2:0] ST_BAD_TYPE    = 3'd4;
   localparam logic [2:0] ST_SHORT_REC   = 3'd5;
   localparam logic [2:0] ST_SHORT_NAMES = 3'd6;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LEN_LO = 2'd1;
   localparam logic [1:0] PH_LEN_HI = 2'd2;
   localparam logic [1:0] PH_CHARS  = 2'd3;

   typedef struct packed {
      logic [31:0] idx;
      logic [63:0] offset;
      logic [31:0] packed_size;
      logic [31:0] unpacked_size;
   } aisp_rec_type;

   typedef struct packed {
      logic [31:0] idx;
      logic [15:0] len;
      logic [7:0]  ch;
   } aisp_name_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  version;
      logic [31:0] count;
   } aisp_fin_type;

   typedef struct packed {
      logic          rec_v;
      aisp_rec_type  rec;
      logic          name_v;
      aisp_name_type name;
      logic          fin_v;
      aisp_fin_type  fin;
   } aisp_push_type;

endpackage

[hdl/aisp_rsp_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_rsp_stage
// Holds up to three pending results of one byte and drains them in order
// (record, name, status) through a registered response port.
// ----------------------------------------------------------------------------
module aisp_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  aisp_pkg::aisp_push_type push,
   output logic                  load_ok,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_result_kind,
   output logic [31:0]           rsp_entry_index,
   output logic [63:0]           rsp_data_offset,
   output logic [31:0]           rsp_packed_size,
   output logic [31:0]           rsp_unpacked_size,
   output logic [15:0]           rsp_name_length,
   output logic [7:0]            rsp_name_char,
   output logic [2:0]            rsp_status,
   output logic [3:0]            rsp_archive_version,
   output logic [31:0]           rsp_entry_count,
   output logic                  rsp_archive_end
);

   logic rec_v_ff, rec_v_in, name_v_ff, name_v_in, fin_v_ff, fin_v_in;
   aisp_pkg::aisp_rec_type  rec_ff;
   aisp_pkg::aisp_name_type name_ff;
   aisp_pkg::aisp_fin_type  fin_ff;

   logic        out_v_ff, out_v_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] idx_ff, idx_in;
   logic [63:0] off_ff, off_in;
   logic [31:0] pk_ff, pk_in, up_ff, up_in, cnt_ff, cnt_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [7:0]  ch_ff, ch_in;
   logic [2:0]  st_ff, st_in;
   logic [3:0]  ver_ff, ver_in;
   logic        end_ff, end_in;

   logic       out_free, take_rec, take_name, take_fin;
   logic [1:0] npend;

   always_comb begin
      out_free  = !out_v_ff || rsp_ready;
      npend     = 2'({1'b0, rec_v_ff}) + 2'({1'b0, name_v_ff}) + 2'({1'b0, fin_v_ff});
      load_ok   = (npend == 2'd0) || ((npend == 2'd1) && out_free);
      take_rec  = out_free && rec_v_ff;
      take_name = out_free && !rec_v_ff && name_v_ff;
      take_fin  = out_free && !rec_v_ff && !name_v_ff && fin_v_ff;

      rec_v_in  = load ? push.rec_v  : (rec_v_ff && !take_rec);
      name_v_in = load ? push.name_v : (name_v_ff && !take_name);
      fin_v_in  = load ? push.fin_v  : (fin_v_ff && !take_fin);

      out_v_in = out_free ? (take_rec || take_name || take_fin) : out_v_ff;
      kind_in = kind_ff; idx_in = idx_ff; off_in = off_ff; pk_in = pk_ff;
      up_in = up_ff; nlen_in = nlen_ff; ch_in = ch_ff; st_in = st_ff;
      ver_in = ver_ff; cnt_in = cnt_ff; end_in = end_ff;
      if (take_rec || take_name || take_fin) begin
         idx_in = '0; off_in = '0; pk_in = '0; up_in = '0; nlen_in = '0;
         ch_in = '0; st_in = '0; ver_in = '0; cnt_in = '0; end_in = 1'b0;
      end
      if (take_rec) begin
         kind_in = aisp_pkg::KIND_RECORD;
         idx_in  = rec_ff.idx;
         off_in  = rec_ff.offset;
         pk_in   = rec_ff.packed_size;
         up_in   = rec_ff.unpacked_size;
      end else if (take_name) begin
         kind_in = aisp_pkg::KIND_NAME;
         idx_in  = name_ff.idx;
         nlen_in = name_ff.len;
         ch_in   = name_ff.ch;
      end else if (take_fin) begin
         kind_in = aisp_pkg::KIND_STATUS;
         st_in   = fin_ff.status;
         ver_in  = fin_ff.version;
         cnt_in  = fin_ff.count;
         end_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_v_ff  <= 1'b0;
         name_v_ff <= 1'b0;
         fin_v_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         rec_v_ff  <= rec_v_in;
         name_v_ff <= name_v_in;
         fin_v_ff  <= fin_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff  <= push.rec;
         name_ff <= push.name;
         fin_ff  <= push.fin;
      end
      kind_ff <= kind_in; idx_ff <= idx_in; off_ff <= off_in; pk_ff <= pk_in;
      up_ff <= up_in; nlen_ff <= nlen_in; ch_ff <= ch_in; st_ff <= st_in;
      ver_ff <= ver_in; cnt_ff <= cnt_in; end_ff <= end_in;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_entry_index     = idx_ff;
   assign rsp_data_offset     = off_ff;
   assign rsp_packed_size     = pk_ff;
   assign rsp_unpacked_size   = up_ff;
   assign rsp_name_length     = nlen_ff;
   assign rsp_name_char       = ch_ff;
   assign rsp_status          = st_ff;
   assign rsp_archive_version = ver_ff;
   assign rsp_entry_count     = cnt_ff;
   assign rsp_archive_end     = end_ff;

endmodule

[hdl/archive_index_stream_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_index_stream_parser_top
// Streaming parser of an archive index: header checks, record fields and
// name table bytes, closed by one status word.
// ----------------------------------------------------------------------------
// usage
// - csr_wr_en / csr_wr_data load the file length; write it while idle
// - req_* carries one archive byte per word, req_start_of_file marks byte 0
//   and restarts parsing
// - rsp_* carries result words: record fields, name bytes, final status
// - a byte is parsed in the cycle it is accepted; its results go through the
//   pending and output registers to rsp_*, a word per cycle while rsp_ready
// - throughput is one byte per cycle while each byte yields at most one word
//   and rsp_ready is high; a byte with two or three words (record end, name
//   byte, status) holds req_ready low while the response stage drains them
// - a name table that starts inside the header is replayed after byte 23
//   from the stored header, req_ready low, one byte per cycle unless stalled
// - after the status word, bytes are taken and dropped until start of file
// - reset clears all parsing state and the file length; no clearing pass
// - a stalled receiver holds the response register; the three-entry pending
//   stage lets one more byte in before req_ready drops
// ----------------------------------------------------------------------------
module archive_index_stream_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_entry_index,
   output logic [63:0] rsp_data_offset,
   output logic [31:0] rsp_packed_size,
   output logic [31:0] rsp_unpacked_size,
   output logic [15:0] rsp_name_length,
   output logic [7:0]  rsp_name_char,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_archive_version,
   output logic [31:0] rsp_entry_count,
   output logic        rsp_archive_end
);

   localparam int HB = aisp_pkg::HEADER_BYTES;

   // configuration
   logic [31:0] file_len_ff;

   // parsing state
   logic [31:0] pos_ff, pos_in;
   logic [31:0] rec_cnt_ff, rec_cnt_in;
   logic [31:0] decl_ff, decl_in;
   logic [31:0] ns_lo_ff, ns_lo_in;
   logic        ns_hi_zero_ff, ns_hi_zero_in;
   logic [31:0] name_cnt_ff, name_cnt_in;
   logic [1:0]  name_ph_ff, name_ph_in;
   logic [15:0] name_rem_ff, name_rem_in;
   logic [15:0] name_len_ff, name_len_in;
   logic        done_ff, done_in;
   logic [5:0]  rec_off_ff, rec_off_in;
   logic        replay_ff, replay_in;
   logic [4:0]  rep_idx_ff, rep_idx_in;

   // byte stores
   logic [7:0]  hdr_ff [HB];
   logic [7:0]  rec_b_ff [aisp_pkg::REC_FIELD_HI - aisp_pkg::REC_FIELD_LO];
   logic        hdr_we, rec_we;
   logic [4:0]  hdr_wa;
   logic [3:0]  rec_wa;

   // record count times record size, from the stored count bytes
   logic [37:0] prod_ff, prod_in;

   logic                    acc, rep_step, load_ok;
   aisp_pkg::aisp_push_type push;

   assign req_ready = load_ok && !replay_ff;
   assign acc       = req_valid && req_ready;
   assign rep_step  = replay_ff && load_ok;

   always_comb begin
      logic [31:0] cnt_h;
      cnt_h   = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
      prod_in = {1'b0, cnt_h, 5'b0} + {4'b0, cnt_h, 2'b0};
   end

   always_comb begin : step_logic
      logic        sof;
      logic [31:0] p, rc, nc, cnt, ver32;
      logic [1:0]  ph;
      logic [15:0] rem, nlen;
      logic [5:0]  off;
      logic        cur_done, nf_en, name_done, post_chk, fin_v;
      logic [7:0]  nf_byte;
      logic [2:0]  st;
      logic [63:0] ns64, room;

      sof      = acc && req_start_of_file;
      p        = sof ? '0 : pos_ff;
      rc       = sof ? '0 : rec_cnt_ff;
      nc       = sof ? '0 : name_cnt_ff;
      cnt      = sof ? '0 : decl_ff;
      ph       = sof ? aisp_pkg::PH_IDLE : name_ph_ff;
      rem      = sof ? '0 : name_rem_ff;
      nlen     = sof ? '0 : name_len_ff;
      off      = sof ? '0 : rec_off_ff;
      cur_done = sof ? 1'b0 : done_ff;

      pos_in        = p;
      ns_lo_in      = ns_lo_ff;
      ns_hi_zero_in = ns_hi_zero_ff;
      rec_off_in    = off;
      replay_in     = replay_ff;
      rep_idx_in    = rep_idx_ff;
      done_in       = cur_done;
      hdr_we        = 1'b0;
      hdr_wa        = p[4:0];
      rec_we        = 1'b0;
      rec_wa        = off[3:0];
      nf_en         = 1'b0;
      nf_byte       = req_byte_value;
      post_chk      = 1'b0;
      fin_v         = 1'b0;
      st            = aisp_pkg::ST_OK;
      name_done     = 1'b0;
      ver32         = {hdr_ff[7], hdr_ff[6], hdr_ff[5], hdr_ff[4]};
      ns64          = {req_byte_value, hdr_ff[22], hdr_ff[21], hdr_ff[20],
                       hdr_ff[19], hdr_ff[18], hdr_ff[17], hdr_ff[16]};
      room          = {32'b0, file_len_ff} - 64'(HB);
      push          = '0;

      if (acc && !cur_done) begin
         if (p < 32'(HB)) hdr_we = 1'b1;
         if (p == '0 && file_len_ff < 32'(HB)) begin
            fin_v = 1'b1;
            st    = aisp_pkg::ST_SHORT_HDR;
         end else if (p == 32'(HB - 1)) begin
            if ({hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]} != aisp_pkg::MAGIC_TAG) begin
               fin_v = 1'b1;
               st    = aisp_pkg::ST_BAD_MAGIC;
            end else if (ver32 < 32'(aisp_pkg::VER_MIN) ||
                         ver32 > 32'(aisp_pkg::VER_MAX)) begin
               fin_v = 1'b1;
               st    = aisp_pkg::ST_BAD_VERSION;
            end else if ({hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]}
                         != aisp_pkg::TYPE_TAG) begin
               fin_v = 1'b1;
               st    = aisp_pkg::ST_BAD_TYPE;
            end else begin
               cnt           = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
               ns_lo_in      = ns64[31:0];
               ns_hi_zero_in = (ns64[63:32] == '0);
               if ({26'b0, prod_ff} > room) begin
                  fin_v = 1'b1;
                  st    = aisp_pkg::ST_SHORT_REC;
               end else if (ns64 > {32'b0, file_len_ff}) begin
                  fin_v = 1'b1;
                  st    = aisp_pkg::ST_SHORT_NAMES;
               end else if (ns64 < 64'(HB) && cnt != '0) begin
                  // name table starts inside the header: replay stored bytes
                  ph         = aisp_pkg::PH_LEN_LO;
                  replay_in  = 1'b1;
                  rep_idx_in = ns64[4:0];
                  pos_in     = p + 32'd1;
               end else begin
                  post_chk = 1'b1;
               end
            end
         end else if (p >= 32'(HB)) begin
            if (rc < cnt) begin
               if (off >= 6'(aisp_pkg::REC_FIELD_LO) && off < 6'(aisp_pkg::REC_FIELD_HI))
                  rec_we = 1'b1;
               if (off == 6'(aisp_pkg::REC_LAST)) begin
                  push.rec_v              = 1'b1;
                  push.rec.idx            = rc;
                  push.rec.offset         = {rec_b_ff[7], rec_b_ff[6], rec_b_ff[5],
                                             rec_b_ff[4], rec_b_ff[3], rec_b_ff[2],
                                             rec_b_ff[1], rec_b_ff[0]};
                  push.rec.packed_size    = {rec_b_ff[11], rec_b_ff[10], rec_b_ff[9],
                                             rec_b_ff[8]};
                  push.rec.unpacked_size  = {rec_b_ff[15], rec_b_ff[14], rec_b_ff[13],
                                             rec_b_ff[12]};
                  rc = rc + 32'd1;
               end
            end
            rec_off_in = (off == 6'(aisp_pkg::REC_LAST)) ? '0 : off + 6'd1;
            if (ph == aisp_pkg::PH_IDLE && nc < cnt && ns_hi_zero_ff && p == ns_lo_ff)
               ph = aisp_pkg::PH_LEN_LO;
            nf_en    = 1'b1;
            post_chk = 1'b1;
         end else begin
            pos_in = p + 32'd1;
         end
      end else if (rep_step) begin
         nf_en      = 1'b1;
         nf_byte    = hdr_ff[rep_idx_ff];
         rep_idx_in = rep_idx_ff + 5'd1;
         if (rep_idx_ff == 5'(HB - 1)) replay_in = 1'b0;
      end

      // name table walker
      if (nf_en) begin
         case (ph)
            aisp_pkg::PH_LEN_LO: begin
               rem = {8'b0, nf_byte};
               ph  = aisp_pkg::PH_LEN_HI;
            end
            aisp_pkg::PH_LEN_HI: begin
               nlen = {nf_byte, rem[7:0]};
               rem  = nlen;
               ph   = aisp_pkg::PH_CHARS;
               if (nlen == '0) name_done = 1'b1;
            end
            aisp_pkg::PH_CHARS: begin
               push.name_v   = 1'b1;
               push.name.idx = nc;
               push.name.len = nlen;
               push.name.ch  = nf_byte;
               rem = rem - 16'd1;
               if (rem == '0) name_done = 1'b1;
            end
            default: begin
            end
         endcase
         if (name_done) begin
            nc = nc + 32'd1;
            ph = (nc == cnt) ? aisp_pkg::PH_IDLE : aisp_pkg::PH_LEN_LO;
         end
      end

      if (post_chk) begin
         if (rc == cnt && nc == cnt) begin
            fin_v = 1'b1;
            st    = aisp_pkg::ST_OK;
         end else if (p == file_len_ff - 32'd1) begin
            fin_v = 1'b1;
            st    = aisp_pkg::ST_SHORT_NAMES;
         end else begin
            pos_in = p + 32'd1;
         end
      end

      if (fin_v) begin
         done_in           = 1'b1;
         push.fin_v        = 1'b1;
         push.fin.status   = st;
         push.fin.version  = (st == aisp_pkg::ST_OK || st >= aisp_pkg::ST_BAD_TYPE) ?
                             hdr_ff[4][3:0] : 4'd0;
         push.fin.count    = (st == aisp_pkg::ST_OK || st >= aisp_pkg::ST_SHORT_REC) ?
                             cnt : 32'd0;
      end

      rec_cnt_in  = rc;
      name_cnt_in = nc;
      decl_in     = cnt;
      name_ph_in  = ph;
      name_rem_in = rem;
      name_len_in = nlen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_len_ff   <= '0;
         pos_ff        <= '0;
         rec_cnt_ff    <= '0;
         decl_ff       <= '0;
         ns_lo_ff      <= '0;
         ns_hi_zero_ff <= 1'b1;
         name_cnt_ff   <= '0;
         name_ph_ff    <= aisp_pkg::PH_IDLE;
         name_rem_ff   <= '0;
         name_len_ff   <= '0;
         done_ff       <= 1'b0;
         rec_off_ff    <= '0;
         replay_ff     <= 1'b0;
         rep_idx_ff    <= '0;
      end else begin
         if (csr_wr_en) file_len_ff <= csr_wr_data;
         pos_ff        <= pos_in;
         rec_cnt_ff    <= rec_cnt_in;
         decl_ff       <= decl_in;
         ns_lo_ff      <= ns_lo_in;
         ns_hi_zero_ff <= ns_hi_zero_in;
         name_cnt_ff   <= name_cnt_in;
         name_ph_ff    <= name_ph_in;
         name_rem_ff   <= name_rem_in;
         name_len_ff   <= name_len_in;
         done_ff       <= done_in;
         rec_off_ff    <= rec_off_in;
         replay_ff     <= replay_in;
         rep_idx_ff    <= rep_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) hdr_ff[hdr_wa] <= req_byte_value;
      if (rec_we) rec_b_ff[rec_wa] <= req_byte_value;
      prod_ff <= prod_in;
   end

   aisp_rsp_stage u_rsp (
      .clock               (clock),
      .reset               (reset),
      .load                (acc || rep_step),
      .push                (push),
      .load_ok             (load_ok),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_data_offset     (rsp_data_offset),
      .rsp_packed_size     (rsp_packed_size),
      .rsp_unpacked_size   (rsp_unpacked_size),
      .rsp_name_length     (rsp_name_length),
      .rsp_name_char       (rsp_name_char),
      .rsp_status          (rsp_status),
      .rsp_archive_version (rsp_archive_version),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_archive_end     (rsp_archive_end)
   );

endmodule

[hdl/aisp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_checker
// Port-level checks of the archive index stream parser response channel.
// ----------------------------------------------------------------------------
module aisp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [31:0] rsp_entry_index,
   input logic [7:0]  rsp_name_char,
   input logic [2:0]  rsp_status,
   input logic        rsp_archive_end
);

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_entry_index) && $stable(rsp_name_char) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // status word always closes the archive
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == aisp_pkg::KIND_STATUS |-> rsp_archive_end)
      else $error("status word without archive end");

   // data words carry no status and no end mark
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != aisp_pkg::KIND_STATUS |->
      !rsp_archive_end && rsp_status == aisp_pkg::ST_OK)
      else $error("data word with status fields set");

   // no unused kind code
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind != 2'd3)
      else $error("unknown result kind");

endmodule

bind archive_index_stream_parser_top aisp_checker u_aisp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_entry_index (rsp_entry_index),
   .rsp_name_char   (rsp_name_char),
   .rsp_status      (rsp_status),
   .rsp_archive_end (rsp_archive_end)
);
